// File: design/bessel_hermite_spline_interp_top_defines.svh
// Assertion macros for the spline interpolator top level.
`ifndef BESSEL_HERMITE_SPLINE_INTERP_TOP_DEFINES_SVH
`define BESSEL_HERMITE_SPLINE_INTERP_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk and disabled in reset.
`define BHS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bhs assertion failed");
// Next-cycle implication, sampled on clk and disabled in reset.
`define BHS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bhs assertion failed");
`else
`define BHS_ASSERT_IMP(lbl, ante, cons)
`define BHS_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// File: design/bhs_pkg.sv
// Package with widths, codes, state type and helpers of the spline interpolator.
package bhs_pkg;

  localparam int MAX_KNOTS = 16;
  localparam int IDX_W     = $clog2(MAX_KNOTS);
  localparam int CNT_W     = 5;
  localparam int X_W       = 18;
  localparam int Y_W       = 32;
  localparam int WORD_W    = X_W + Y_W;

  // Divider: numerator is sized for x << 32, denominator for a sum of two widths.
  localparam int NUM_W     = X_W + 32;
  localparam int DEN_W     = X_W + 1;
  localparam int DIV_STEPS = NUM_W / 2;
  localparam int DCNT_W    = $clog2(DIV_STEPS);

  // Datapath values and multiplier shape.
  localparam int VAL_W     = 58;
  localparam int MB_W      = 33;
  localparam int PROD_W    = VAL_W + MB_W;
  localparam int MUL_CHUNK = 8;
  localparam int MUL_STEPS = (MB_W + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int MUL_PAD_W = MUL_STEPS * MUL_CHUNK;
  localparam int MCNT_W    = $clog2(MUL_STEPS);
  localparam int FRAC_SH   = 32;
  localparam int LEN_SH    = 16;

  // Command codes.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE, ST_SCAN_RD, ST_SCAN_CMP, ST_FP_RD, ST_FN_RD, ST_FN_CAP,
    ST_OP_M, ST_OP_MP, ST_OP_W0, ST_OP_D0, ST_OP_MN, ST_OP_W1, ST_OP_D1,
    ST_OP_F, ST_OP_G0, ST_OP_G1, ST_OP_S, ST_OP_AB,
    ST_OP_R1, ST_OP_R2, ST_OP_R3, ST_DONE
  } state_t;

  // States that run the shared divider.
  function automatic logic is_div_state(state_t s);
    return (s == ST_OP_M) || (s == ST_OP_MP) || (s == ST_OP_W0) ||
           (s == ST_OP_MN) || (s == ST_OP_W1) || (s == ST_OP_S);
  endfunction

  // States that run the shared multiplier.
  function automatic logic is_mul_state(state_t s);
    return (s == ST_OP_D0) || (s == ST_OP_D1) || (s == ST_OP_G0) ||
           (s == ST_OP_G1) || (s == ST_OP_R1) || (s == ST_OP_R2) ||
           (s == ST_OP_R3);
  endfunction

endpackage

// File: design/bhs_cmd_if.sv
// Command channel: knot writes and queries.
interface bhs_cmd_if;
  import bhs_pkg::*;
  logic             valid;
  logic             ready;
  logic             opcode;
  logic [IDX_W-1:0] knot_index;
  logic [X_W-1:0]   knot_x;
  logic signed [Y_W-1:0] knot_y;
  logic [X_W-1:0]   query_x;

  modport source (output valid, opcode, knot_index, knot_x, knot_y, query_x,
                  input ready);
  modport sink   (input valid, opcode, knot_index, knot_x, knot_y, query_x,
                  output ready);
endinterface

// File: design/bhs_res_if.sv
// Result channel: interpolated value and extrapolation flag.
interface bhs_res_if;
  import bhs_pkg::*;
  logic                  valid;
  logic                  ready;
  logic signed [Y_W-1:0] value;
  logic                  extrapolated;

  modport source (output valid, value, extrapolated, input ready);
  modport sink   (input valid, value, extrapolated, output ready);
endinterface

// File: design/bhs_div.sv
// Unsigned restoring divider, two quotient bits per cycle.
module bhs_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [bhs_pkg::NUM_W-1:0]  num,
  input  logic [bhs_pkg::DEN_W-1:0]  den,
  output logic                       done,
  output logic [bhs_pkg::NUM_W-1:0]  quo
);
  import bhs_pkg::*;

  logic [DEN_W-1:0]  rem;
  logic [DEN_W-1:0]  den_r;
  logic [NUM_W-1:0]  qsh;
  logic [DCNT_W-1:0] cnt;
  logic              busy;

  logic [DEN_W:0]    r1w, r2w, r1s, r2s;
  logic              ge1, ge2;

  // Two dependent compare-and-subtract steps.
  always_comb begin
    r1w = {rem, qsh[NUM_W-1]};
    ge1 = r1w >= {1'b0, den_r};
    r1s = ge1 ? r1w - {1'b0, den_r} : r1w;
    r2w = {r1s[DEN_W-1:0], qsh[NUM_W-2]};
    ge2 = r2w >= {1'b0, den_r};
    r2s = ge2 ? r2w - {1'b0, den_r} : r2w;
  end

  // Control: busy while the steps run, done pulses as the last step completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DCNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Remainder and numerator/quotient shift register.
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      den_r <= den;
      qsh   <= num;
    end else if (busy) begin
      rem <= r2s[DEN_W-1:0];
      qsh <= {qsh[NUM_W-3:0], ge1, ge2};
    end
  end

  assign quo = qsh;

endmodule

// File: design/bhs_mul.sv
// Unsigned multiplier, one 8-bit digit of the short operand per cycle.
module bhs_mul (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [bhs_pkg::VAL_W-1:0]  a,
  input  logic [bhs_pkg::MB_W-1:0]   b,
  output logic                       done,
  output logic [bhs_pkg::PROD_W-1:0] prod
);
  import bhs_pkg::*;

  logic [VAL_W-1:0]     a_r;
  logic [MUL_PAD_W-1:0] bsh;
  logic [PROD_W-1:0]    acc;
  logic [MCNT_W-1:0]    cnt;
  logic                 busy;

  logic [MUL_CHUNK-1:0]       digit;
  logic [VAL_W+MUL_CHUNK-1:0] pp;
  logic [PROD_W-1:0]          acc_next;

  // Most significant digit first: acc = acc * 256 + a * digit.
  always_comb begin
    digit    = bsh[MUL_PAD_W-1 -: MUL_CHUNK];
    pp       = {{MUL_CHUNK{1'b0}}, a_r} * {{VAL_W{1'b0}}, digit};
    acc_next = {acc[PROD_W-MUL_CHUNK-1:0], {MUL_CHUNK{1'b0}}} +
               {{(PROD_W-VAL_W-MUL_CHUNK){1'b0}}, pp};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == MCNT_W'(MUL_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      bsh <= {{(MUL_PAD_W-MB_W){1'b0}}, b};
      acc <= '0;
    end else if (busy) begin
      acc <= acc_next;
      bsh <= {bsh[MUL_PAD_W-MUL_CHUNK-1:0], {MUL_CHUNK{1'b0}}};
    end
  end

  assign prod = acc;

endmodule

// File: design/bessel_hermite_spline_interp_top.sv
// Top level of the Bessel cubic Hermite spline interpolator.
//
// Usage: the cmd channel takes two kinds of beats. A write beat (opcode 0)
// stores knot_x/knot_y at knot_index in the knot memory and gives no result.
// A query beat (opcode 1) gives exactly one beat on the result channel with
// value (signed Q16.16, saturated) and extrapolated. Knots must be strictly
// increasing in x and written before a query reads them. The user must set
// knot_count through cfg_we/cfg_wdata only while the block is idle, as the block
// does not enforce it; values below 2 act as 2 and values above 16 act as 16.
// A write beat is stored in the knot memory as it is accepted. A query scans
// the knot memory with a read state and a compare state per knot, since the
// memory read is registered, so a query outside the knots ends after the scan.
// Inside the range it adds the neighbor fetch states FP_RD, FN_RD and FN_CAP
// and up to six divisions on the radix-4 divider plus up to seven multiplies
// on the digit multiplier. One item is worked on at a time.
// The result sits in an output register: the next beat is accepted while it
// waits, and a stalled receiver only holds a finished query in its last state.
// Reset clears the control state and sets knot_count to 2; the knot memory
// is not cleared.
module bessel_hermite_spline_interp_top (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [bhs_pkg::CNT_W-1:0] cfg_wdata,
  bhs_cmd_if.sink                   cmd,
  bhs_res_if.source                 result
);
  import bhs_pkg::*;
  `include "bessel_hermite_spline_interp_top_defines.svh"

  // Configuration and control registers.
  logic [CNT_W-1:0] knot_count;
  logic [CNT_W-1:0] n_eff;
  state_t           state, state_next;
  logic [IDX_W-1:0] idx;
  logic             op_busy;
  logic             out_valid;
  logic signed [Y_W-1:0] out_value;
  logic             out_ext;

  // Knot memory, x over y in one word.
  logic [WORD_W-1:0] knot_mem [MAX_KNOTS];
  logic [WORD_W-1:0] rd_data;
  logic [IDX_W-1:0]  rd_addr;
  logic              mem_we;

  // Query datapath registers.
  logic [X_W-1:0]          query;
  logic [WORD_W-1:0]       prev_word;
  logic [X_W-1:0]          xl, xu, xp, xn;
  logic signed [Y_W-1:0]   yl, yu, yp, yn;
  logic signed [VAL_W-1:0] m, mp, mn, d0, d1, f0, f1, g0, g1, a_c, b_c, r;
  logic [MB_W-1:0]         w0, w1, s;
  logic signed [Y_W-1:0]   res_value;
  logic                    res_ext;

  // Derived values.
  logic [X_W-1:0]          h, t, hp, hn, rd_x;
  logic signed [Y_W-1:0]   rd_y;
  logic signed [Y_W:0]     dy, dyp, dyn;
  logic                    prev_ok, next_ok, has_prev, has_next, hit, last;
  logic signed [VAL_W-1:0] dy_ext, sum_out;

  // Shared units.
  logic               div_start, div_done, div_neg;
  logic [NUM_W-1:0]   div_num, div_quo;
  logic [DEN_W-1:0]   div_den;
  logic signed [VAL_W-1:0] div_slope;
  logic               mul_start, mul_done, mul_short;
  logic signed [VAL_W-1:0] mul_v, mul_res;
  logic [MB_W-1:0]    mul_b;
  logic [VAL_W-1:0]   mul_mag, mul_shifted;
  logic [PROD_W-1:0]  mul_prod;
  logic               op_done, out_load;

  function automatic logic [Y_W-1:0] mag_dy(logic signed [Y_W:0] v);
    logic [Y_W:0] u;
    u = v[Y_W] ? -v : v;
    return u[Y_W-1:0];
  endfunction

  function automatic logic [VAL_W-1:0] mag_v(logic signed [VAL_W-1:0] v);
    return v[VAL_W-1] ? -v : v;
  endfunction

  // Effective knot count, clamped to the supported range.
  always_comb begin
    priority if (knot_count < CNT_W'(2))         n_eff = CNT_W'(2);
    else if (knot_count > CNT_W'(MAX_KNOTS))     n_eff = CNT_W'(MAX_KNOTS);
    else                                         n_eff = knot_count;
  end

  // Interval geometry and neighbor checks.
  always_comb begin
    rd_x     = rd_data[WORD_W-1 -: X_W];
    rd_y     = rd_data[Y_W-1:0];
    hit      = query < rd_x;
    last     = {1'b0, idx} == n_eff - 1'b1;
    h        = xu - xl;
    t        = query - xl;
    hp       = xl - xp;
    hn       = xn - xu;
    dy       = {yu[Y_W-1], yu} - {yl[Y_W-1], yl};
    dyp      = {yl[Y_W-1], yl} - {yp[Y_W-1], yp};
    dyn      = {yn[Y_W-1], yn} - {yu[Y_W-1], yu};
    prev_ok  = idx >= IDX_W'(2);
    next_ok  = ({1'b0, idx} + 1'b1) < n_eff;
    has_prev = prev_ok && (xl > xp);
    has_next = next_ok && (xn > xu);
    dy_ext   = VAL_W'(dy);
    sum_out  = VAL_W'(yl) + mul_res;
  end

  // Divider operand selection.
  always_comb begin
    div_num = '0;
    div_den = '0;
    div_neg = 1'b0;
    unique case (state)
      ST_OP_M: begin
        div_num = NUM_W'({mag_dy(dy), 16'b0});
        div_den = {1'b0, h};
        div_neg = dy[Y_W];
      end
      ST_OP_MP: begin
        div_num = NUM_W'({mag_dy(dyp), 16'b0});
        div_den = {1'b0, hp};
        div_neg = dyp[Y_W];
      end
      ST_OP_MN: begin
        div_num = NUM_W'({mag_dy(dyn), 16'b0});
        div_den = {1'b0, hn};
        div_neg = dyn[Y_W];
      end
      ST_OP_W0: begin
        div_num = {h, 32'b0};
        div_den = {1'b0, hp} + {1'b0, h};
      end
      ST_OP_W1: begin
        div_num = {h, 32'b0};
        div_den = {1'b0, h} + {1'b0, hn};
      end
      ST_OP_S: begin
        div_num = {t, 32'b0};
        div_den = {1'b0, h};
      end
      default: ;
    endcase
    div_slope = div_neg ? -$signed(VAL_W'(div_quo)) : $signed(VAL_W'(div_quo));
  end

  // Multiplier operand selection and result scaling.
  always_comb begin
    mul_v     = '0;
    mul_b     = '0;
    mul_short = 1'b0;
    unique case (state)
      ST_OP_D0: begin mul_v = mp - m;  mul_b = w0; end
      ST_OP_D1: begin mul_v = mn - m;  mul_b = w1; end
      ST_OP_G0: begin mul_v = f0; mul_b = MB_W'(h); mul_short = 1'b1; end
      ST_OP_G1: begin mul_v = f1; mul_b = MB_W'(h); mul_short = 1'b1; end
      ST_OP_R1: begin mul_v = b_c;     mul_b = s; end
      ST_OP_R2: begin mul_v = a_c + r; mul_b = s; end
      ST_OP_R3: begin mul_v = g0 + r;  mul_b = s; end
      default: ;
    endcase
    mul_mag     = mag_v(mul_v);
    mul_shifted = mul_short ? mul_prod[LEN_SH +: VAL_W] : mul_prod[FRAC_SH +: VAL_W];
    mul_res     = mul_v[VAL_W-1] ? -$signed(mul_shifted) : $signed(mul_shifted);
  end

  bhs_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  bhs_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_mag),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  assign op_done  = op_busy && (div_done || mul_done);
  assign out_load = (state == ST_DONE) && (!out_valid || result.ready);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:
        if (cmd.valid && cmd.opcode == OP_QUERY) state_next = ST_SCAN_RD;
      ST_SCAN_RD:  state_next = ST_SCAN_CMP;
      ST_SCAN_CMP: begin
        priority if (hit && idx == '0) state_next = ST_DONE;
        else if (hit)                  state_next = ST_FP_RD;
        else if (last)                 state_next = ST_DONE;
        else                           state_next = ST_SCAN_RD;
      end
      ST_FP_RD:  state_next = ST_FN_RD;
      ST_FN_RD:  state_next = ST_FN_CAP;
      ST_FN_CAP: state_next = ST_OP_M;
      ST_OP_M:
        if (op_done) begin
          priority if (has_prev) state_next = ST_OP_MP;
          else if (has_next)     state_next = ST_OP_MN;
          else                   state_next = ST_OP_F;
        end
      ST_OP_MP: if (op_done) state_next = ST_OP_W0;
      ST_OP_W0: if (op_done) state_next = ST_OP_D0;
      ST_OP_D0: if (op_done) state_next = has_next ? ST_OP_MN : ST_OP_F;
      ST_OP_MN: if (op_done) state_next = ST_OP_W1;
      ST_OP_W1: if (op_done) state_next = ST_OP_D1;
      ST_OP_D1: if (op_done) state_next = ST_OP_F;
      ST_OP_F:  state_next = ST_OP_G0;
      ST_OP_G0: if (op_done) state_next = ST_OP_G1;
      ST_OP_G1: if (op_done) state_next = ST_OP_S;
      ST_OP_S:  if (op_done) state_next = ST_OP_AB;
      ST_OP_AB: state_next = ST_OP_R1;
      ST_OP_R1: if (op_done) state_next = ST_OP_R2;
      ST_OP_R2: if (op_done) state_next = ST_OP_R3;
      ST_OP_R3: if (op_done) state_next = ST_DONE;
      ST_DONE:  if (out_load) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    cmd.ready = state == ST_IDLE;
    mem_we    = cmd.valid && cmd.ready && cmd.opcode == OP_WRITE;
    div_start = is_div_state(state) && !op_busy;
    mul_start = is_mul_state(state) && !op_busy;
    unique case (state)
      ST_FP_RD: rd_addr = idx - IDX_W'(2);
      ST_FN_RD: rd_addr = idx + 1'b1;
      default:  rd_addr = idx;
    endcase
  end

  // Knot memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) knot_mem[cmd.knot_index] <= {cmd.knot_x, cmd.knot_y};
    rd_data <= knot_mem[rd_addr];
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      knot_count <= CNT_W'(2);
      op_busy    <= 1'b0;
      out_valid  <= 1'b0;
      idx        <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) knot_count <= cfg_wdata;
      if (div_start || mul_start) op_busy <= 1'b1;
      else if (op_done)           op_busy <= 1'b0;
      if (out_load)                       out_valid <= 1'b1;
      else if (result.ready)              out_valid <= 1'b0;
      if (state == ST_IDLE)                        idx <= '0;
      else if (state == ST_SCAN_CMP && !hit && !last) idx <= idx + 1'b1;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) query <= cmd.query_x;
    if (out_load) begin
      out_value <= res_value;
      out_ext   <= res_ext;
    end
    unique case (state)
      ST_SCAN_CMP: begin
        prev_word <= rd_data;
        if (hit && idx == '0) begin
          res_value <= rd_y;
          res_ext   <= 1'b1;
        end else if (hit) begin
          xl <= prev_word[WORD_W-1 -: X_W];
          yl <= prev_word[Y_W-1:0];
          xu <= rd_x;
          yu <= rd_y;
        end else if (last) begin
          res_value <= rd_y;
          res_ext   <= query != rd_x;
        end
      end
      ST_FN_RD: begin
        xp <= rd_x;
        yp <= rd_y;
      end
      ST_FN_CAP: begin
        xn <= rd_x;
        yn <= rd_y;
      end
      ST_OP_M:  if (op_done) m  <= div_slope;
      ST_OP_MP: if (op_done) mp <= div_slope;
      ST_OP_MN: if (op_done) mn <= div_slope;
      ST_OP_W0: if (op_done) w0 <= div_quo[MB_W-1:0];
      ST_OP_W1: if (op_done) w1 <= div_quo[MB_W-1:0];
      ST_OP_S:  if (op_done) s  <= div_quo[MB_W-1:0];
      ST_OP_D0: if (op_done) d0 <= mul_res;
      ST_OP_D1: if (op_done) d1 <= mul_res;
      ST_OP_F: begin
        // End derivatives; a missing side mirrors the other one, with neither both are m.
        priority if (has_prev && has_next) begin
          f0 <= m + d0;
          f1 <= m + d1;
        end else if (has_next) begin
          f0 <= m - d1;
          f1 <= m + d1;
        end else if (has_prev) begin
          f0 <= m + d0;
          f1 <= m - d0;
        end else begin
          f0 <= m;
          f1 <= m;
        end
      end
      ST_OP_G0: if (op_done) g0 <= mul_res;
      ST_OP_G1: if (op_done) g1 <= mul_res;
      ST_OP_AB: begin
        a_c <= (dy_ext <<< 1) + dy_ext - g1 - (g0 <<< 1);
        b_c <= g1 + g0 - (dy_ext <<< 1);
      end
      ST_OP_R1: if (op_done) r <= mul_res;
      ST_OP_R2: if (op_done) r <= mul_res;
      ST_OP_R3:
        if (op_done) begin
          // Saturate y_l + r to signed 32 bits.
          priority if (!sum_out[VAL_W-1] && (|sum_out[VAL_W-2:Y_W-1]))
            res_value <= {1'b0, {(Y_W-1){1'b1}}};
          else if (sum_out[VAL_W-1] && !(&sum_out[VAL_W-2:Y_W-1]))
            res_value <= {1'b1, {(Y_W-1){1'b0}}};
          else
            res_value <= sum_out[Y_W-1:0];
          res_ext <= 1'b0;
        end
      default: ;
    endcase
  end

  assign result.valid        = out_valid;
  assign result.value        = out_value;
  assign result.extrapolated = out_ext;

  // Consistency checks.
  `BHS_ASSERT_NXT(a_query_starts_scan, cmd.valid && cmd.ready && cmd.opcode == OP_QUERY, state == ST_SCAN_RD)
  `BHS_ASSERT_IMP(a_unit_done_busy, div_done || mul_done, op_busy)
  `BHS_ASSERT_IMP(a_busy_in_op, op_busy, is_div_state(state) || is_mul_state(state))
  `BHS_ASSERT_IMP(a_scan_in_range, state == ST_SCAN_CMP, {1'b0, idx} < n_eff)
  `BHS_ASSERT_NXT(a_done_loads_out, out_load, out_valid && state == ST_IDLE)

endmodule
